// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the bounding box blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked property, off while reset is held
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, also during reset
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared codes and types of the bounding box accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_CIRCLE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam int RADIUS_W = 31;
    localparam int NORMAL_W = 16;
    localparam int ROOT_W   = 16;
    localparam int RAD_IN_W = 31;

    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_LAST = 2'd2;

    typedef struct packed {
        logic  upd;
        logic  clear;
        t_axis axis;
    } t_bound_cmd;

endpackage

`default_nettype wire

// File: src/bba_mul.sv
// ----------------------------------------------------------------------------
// bba_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_mul (
    input  wire               i_clk,
    input  wire signed [16:0] i_a,
    input  wire signed [31:0] i_b,
    output logic signed [48:0] o_p
);
    logic signed [48:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 49'(i_a) * 49'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: src/bba_isqrt.sv
// ----------------------------------------------------------------------------
// bba_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bba_isqrt (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [30:0] i_radicand,
    output logic        o_done,
    output logic [15:0] o_root
);
    import bba_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [30:0] r_x;
    logic [30:0] r_res;
    logic [30:0] r_bit;
    logic [31:0] n_trial;
    logic        n_take;

    always_comb begin
        n_trial = {1'b0, r_res} + {1'b0, r_bit};
        n_take  = ({1'b0, r_x} >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_radicand;
                r_res  <= '0;
                r_bit  <= 31'h4000_0000;
            end else if (r_busy) begin
                if (n_take) begin
                    r_x   <= 31'({1'b0, r_x} - n_trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                // last bit pair
                if (r_bit == 31'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

    `BBA_ASSERT(a_root_range, i_clk, i_rst_n, o_done |-> o_root <= 16'd32768, "root out of range")

endmodule

`default_nettype wire

// File: src/bba_bounds.sv
// ----------------------------------------------------------------------------
// bba_bounds
// box bound registers with saturating widen and clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bba_bounds #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire bba_pkg::t_bound_cmd       i_cmd,
    input  wire  signed [COORD_WIDTH-1:0]  i_center,
    input  wire  [30:0]                    i_reach,
    output logic signed [COORD_WIDTH-1:0]  o_lower [3],
    output logic signed [COORD_WIDTH-1:0]  o_upper [3]
);
    import bba_pkg::*;

    localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam int SW = EW + 2;
    localparam logic signed [COORD_WIDTH-1:0] B_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] B_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] S_MIN = ~S_MAX;

    logic signed [COORD_WIDTH-1:0] r_lower [3];
    logic signed [COORD_WIDTH-1:0] r_upper [3];

    logic signed [SW-1:0]          n_c;
    logic signed [SW-1:0]          n_r;
    logic signed [SW-1:0]          n_lo_w;
    logic signed [SW-1:0]          n_hi_w;
    logic signed [COORD_WIDTH-1:0] n_lo;
    logic signed [COORD_WIDTH-1:0] n_hi;

    always_comb begin
        n_c    = SW'(i_center);
        n_r    = SW'(signed'({1'b0, i_reach}));
        n_lo_w = n_c - n_r;
        n_hi_w = n_c + n_r;
        if (n_lo_w < S_MIN) begin
            n_lo = B_MIN;
        end else begin
            n_lo = n_lo_w[COORD_WIDTH-1:0];
        end
        if (n_hi_w > S_MAX) begin
            n_hi = B_MAX;
        end else begin
            n_hi = n_hi_w[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 3; i++) begin
                r_lower[i] <= B_MAX;
                r_upper[i] <= B_MIN;
            end
        end else if (i_cmd.upd) begin
            if (n_lo < r_lower[i_cmd.axis]) begin
                r_lower[i_cmd.axis] <= n_lo;
            end
            if (n_hi > r_upper[i_cmd.axis]) begin
                r_upper[i_cmd.axis] <= n_hi;
            end
        end
    end

    assign o_lower = r_lower;
    assign o_upper = r_upper;

    // either a proper interval or the empty marker
    `BBA_ASSERT(a_box_x, i_clk, i_rst_n, (r_lower[0] <= r_upper[0]) || (r_lower[0] == B_MAX && r_upper[0] == B_MIN), "x bounds crossed")
    `BBA_ASSERT(a_box_y, i_clk, i_rst_n, (r_lower[1] <= r_upper[1]) || (r_lower[1] == B_MAX && r_upper[1] == B_MIN), "y bounds crossed")
    `BBA_ASSERT(a_box_z, i_clk, i_rst_n, (r_lower[2] <= r_upper[2]) || (r_lower[2] == B_MAX && r_upper[2] == B_MIN), "z bounds crossed")

endmodule

`default_nettype wire

// File: src/bounding_box_accumulator.sv
// ----------------------------------------------------------------------------
// bounding_box_accumulator
// running axis-aligned box grown by point, sphere and circle words
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one primitive per word, tuser is the op code
//   (point, sphere, circle, clear); master stream returns the whole box
//   after every word.
//   the block works on one word at a time and drops s_axis_tready while
//   busy. each axis of a circle word runs through one shared multiplier,
//   one 16-step square root and one saturating bounds adder, in turn.
//   steps from accept to result: a clear word empties the bounds and
//   loads the box; a point or sphere word updates the bounds of each axis
//   in turn; a circle word takes per axis a square, an iterative root,
//   a scale multiply and a bound update. the next word is taken only
//   after the result is loaded and the block is back in idle.
//   the result sits in an output register; a new word is accepted while
//   it waits, but that word's result holds until the old one is taken.
//   reset empties the box (min most positive, max most negative) and
//   drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounding_box_accumulator #(
    parameter int COORD_WIDTH = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // center_x, center_y, center_z, normal_x, normal_y, normal_z, radius, pad
    input  wire  [175:0] i_s_axis_tdata,
    // op
    input  wire  [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    output logic [191:0] o_m_axis_tdata
);
    import bba_pkg::*;

    localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam logic signed [EW-1:0] C_MAX = EW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [EW-1:0] C_MIN = ~C_MAX;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SQ, S_SQW, S_ROOT, S_SCALE, S_SCW, S_UPD, S_DONE
    } t_state;

    t_state                        r_state;
    logic                          r_out_valid;
    logic [191:0]                  r_out_data;
    logic [1:0]                    r_op;
    t_axis                         r_axis;
    logic signed [COORD_WIDTH-1:0] r_center [3];
    logic signed [NORMAL_W-1:0]    r_normal [3];
    logic [RADIUS_W-1:0]           r_radius;
    logic [RADIUS_W-1:0]           r_reach;

    logic signed [COORD_WIDTH-1:0] n_center [3];
    logic signed [EW-1:0]          n_ext    [3];
    logic signed [16:0]            w_mul_a;
    logic signed [31:0]            w_mul_b;
    logic signed [48:0]            w_mul_p;
    logic signed [32:0]            w_diff;
    logic [30:0]                   w_radicand;
    logic [46:0]                   w_round;
    logic                          w_root_done;
    logic [ROOT_W-1:0]             w_root;
    t_bound_cmd                    w_cmd;
    logic signed [COORD_WIDTH-1:0] w_lower [3];
    logic signed [COORD_WIDTH-1:0] w_upper [3];
    logic                          w_in_acc;
    logic                          w_out_free;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // clamp incoming centers into the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ext[i] = EW'(signed'(i_s_axis_tdata[32*i +: 32]));
            if (n_ext[i] > C_MAX) begin
                n_center[i] = C_MAX[COORD_WIDTH-1:0];
            end else if (n_ext[i] < C_MIN) begin
                n_center[i] = C_MIN[COORD_WIDTH-1:0];
            end else begin
                n_center[i] = n_ext[i][COORD_WIDTH-1:0];
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ: begin
                w_mul_a = 17'(r_normal[r_axis]);
                w_mul_b = 32'(r_normal[r_axis]);
            end
            S_SCALE: begin
                w_mul_a = signed'({1'b0, w_root});
                w_mul_b = signed'({1'b0, r_radius});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_diff = 33'sh0_4000_0000 - w_mul_p[32:0];
        if (w_diff[32]) begin
            w_radicand = '0;
        end else begin
            w_radicand = w_diff[30:0];
        end
        // round to nearest, ties up
        w_round = w_mul_p[46:0] + 47'h4000;
    end

    always_comb begin
        w_cmd.upd   = (r_state == S_UPD);
        w_cmd.clear = (r_state == S_DISP) && (r_op == OP_CLEAR);
        w_cmd.axis  = r_axis;
    end

    bba_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    bba_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SQW),
        .i_radicand (w_radicand),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    bba_bounds #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_center (r_center[r_axis]),
        .i_reach  (r_reach),
        .o_lower  (w_lower),
        .o_upper  (w_upper)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a word loaded in S_DONE replaces the one taken this cycle
            if (r_out_valid && i_m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op     <= i_s_axis_tuser;
                        r_axis   <= '0;
                        r_radius <= i_s_axis_tdata[144 +: RAD_IN_W];
                        for (int i = 0; i < 3; i++) begin
                            r_center[i] <= n_center[i];
                            r_normal[i] <= signed'(i_s_axis_tdata[96 + 16*i +: 16]);
                        end
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_op)
                        OP_POINT: begin
                            r_reach <= '0;
                            r_state <= S_UPD;
                        end
                        OP_SPHERE: begin
                            r_reach <= r_radius;
                            r_state <= S_UPD;
                        end
                        OP_CIRCLE: begin
                            r_state <= S_SQ;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SQ: begin
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_SCW;
                end
                S_SCW: begin
                    r_reach <= w_round[45:15];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_axis == AXIS_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_DISP;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_out_data[32*i +: 32]      <= 32'(w_lower[i]);
                            r_out_data[96 + 32*i +: 32] <= 32'(w_upper[i]);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `BBA_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")
    `BBA_ASSERT(a_busy, i_clk, i_rst_n, w_in_acc |=> !o_s_axis_tready, "ready while word in work")
    `BBA_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result dropped while stalled")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounding box accumulator: drives point,
// sphere, circle and clear words, predicts the running box and compares
// every returned box word, with idle and stall phases on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import bba_pkg::*;

    localparam longint COORD_TOP  = (64'sd1 <<< 31) - 1;
    localparam longint COORD_BOT  = -(64'sd1 <<< 31);
    localparam longint ONE_Q30    = 64'sd1 <<< 30;
    localparam int     STALL_LIMIT = 4000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [175:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [191:0] o_m_axis_tdata;

    bounding_box_accumulator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // center_x, center_y, center_z, normal_x, normal_y, normal_z, radius, pad
        .i_s_axis_tdata  (i_s_axis_tdata),
        // op
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predicted box, lower and upper bound per axis
    longint       box_lo [3];
    longint       box_hi [3];
    logic [191:0] box_result_q [$];
    logic [191:0] box_want;

    int errors       = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold    = 0;
    int stall_cycles = 0;

    string field_name [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic longint clamp_coord(longint v);
        if (v > COORD_TOP) return COORD_TOP;
        if (v < COORD_BOT) return COORD_BOT;
        return v;
    endfunction

    // floor square root, built msb first
    function automatic longint root_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r + (64'sd1 <<< b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic void empty_box();
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = COORD_TOP;
            box_hi[a] = COORD_BOT;
        end
    endfunction

    function automatic void widen_axis(int a, longint lo, longint hi);
        if (lo < box_lo[a]) box_lo[a] = lo;
        if (hi > box_hi[a]) box_hi[a] = hi;
    endfunction

    function automatic void predict_box(logic [1:0] op, logic [175:0] word);
        longint       ctr;
        longint       nrm;
        longint       rad;
        longint       diff;
        longint       reach;
        logic [191:0] res;
        rad = longint'({33'd0, word[174:144]});
        for (int a = 0; a < 3; a++) begin
            ctr = longint'($signed(word[a*32 +: 32]));
            nrm = longint'($signed(word[96 + a*16 +: 16]));
            case (op)
                OP_POINT: begin
                    widen_axis(a, ctr, ctr);
                end
                OP_SPHERE: begin
                    widen_axis(a, clamp_coord(ctr - rad), clamp_coord(ctr + rad));
                end
                OP_CIRCLE: begin
                    diff = ONE_Q30 - nrm * nrm;
                    if (diff < 0) diff = 0;
                    reach = (root_floor(diff) * rad + (64'sd1 <<< 14)) >>> 15;
                    widen_axis(a, clamp_coord(ctr - reach), clamp_coord(ctr + reach));
                end
                default: ;
            endcase
        end
        if (op == OP_CLEAR) empty_box();
        for (int a = 0; a < 3; a++) begin
            res[a*32 +: 32]      = box_lo[a][31:0];
            res[96 + a*32 +: 32] = box_hi[a][31:0];
        end
        box_result_q.push_back(res);
    endfunction

    // ---------------- stream drivers ----------------

    task automatic send_word(input logic [1:0] op, input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [15:0] nx, input logic [15:0] ny,
                             input logic [15:0] nz, input logic [30:0] rad);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  = {1'b0, rad, nz, ny, nx, cz, cy, cx};
        i_s_axis_tuser  = op;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_box(op, i_s_axis_tdata);
    endtask

    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            i_m_axis_tready = 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------- result check ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (box_result_q.size() == 0) begin
                $display("%0t: box word with nothing pending, got %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                box_want = box_result_q.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (box_want[f*32 +: 32] !== o_m_axis_tdata[f*32 +: 32]) begin
                        $display("%0t: %s expected %h got %h", $time, field_name[f],
                                 box_want[f*32 +: 32], o_m_axis_tdata[f*32 +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // ---------------- random fields ----------------

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
            4, 5, 6:    return $urandom;
            7:          return 32'h7FFFFFFF - $urandom_range(0, 32'hFFFF);
            8:          return 32'h80000000 + $urandom_range(0, 32'hFFFF);
            default:    return 32'h0;
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 31'($urandom_range(0, 32'hFFFFF));
            4, 5:       return r[30:0];
            6:          return 31'h0;
            default:    return 31'h7FFFFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_normal();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: return r[15:0];
            3:       return 16'h8000;
            4:       return 16'h7FFF;
            5:       return 16'h0;
            6:       return 16'($urandom_range(0, 16'h1FFF) - 32'h1000);
            default: return 16'h4000 ^ {15'd0, r[0]} ^ {r[1], 15'd0};
        endcase
    endfunction

    task automatic send_random_word();
        logic [1:0] op;
        int         pick;
        pick = $urandom_range(0, 31);
        if (pick < 2)       op = OP_CLEAR;
        else if (pick < 12) op = OP_POINT;
        else if (pick < 22) op = OP_SPHERE;
        else                op = OP_CIRCLE;
        send_word(op, rand_coord(), rand_coord(), rand_coord(),
                  rand_normal(), rand_normal(), rand_normal(), rand_radius());
    endtask

    // ---------------- tests ----------------

    task automatic test_edge_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // clear on an already empty box, junk in the ignored fields
        send_word(OP_CLEAR, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  16'hFFFF, 16'h8000, 16'h7FFF, 31'h7FFFFFFF);
        send_word(OP_POINT, 32'h0, 32'h0, 32'h0, 16'h1234, 16'hFFFF, 16'h8000, 31'h7FFFFFFF);
        send_word(OP_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 16'h0, 16'h0, 31'h0);
        send_word(OP_POINT, 32'h80000000, 32'h80000000, 32'h80000000, 16'h0, 16'h0, 16'h0, 31'h0);
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 31'h0);
        // sphere saturating both ways, normals ignored
        send_word(OP_SPHERE, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                  16'h8000, 16'h7FFF, 16'h5555, 31'h7FFFFFFF);
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 31'h0);
        send_word(OP_SPHERE, 32'h00020000, 32'hFFFE0000, 32'h0, 16'h0, 16'h0, 16'h0, 31'h0);
        send_word(OP_SPHERE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 16'h0, 16'h0, 16'h0, 31'h1);
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 31'h0);
        // circle with full unit normals: zero reach, only the centre lands
        send_word(OP_CIRCLE, 32'h00030000, 32'hFFFD0000, 32'h00001234,
                  16'h8000, 16'h8000, 16'h8000, 31'h7FFFFFFF);
        // axis-aligned normal on x
        send_word(OP_CIRCLE, 32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h0, 16'h0, 31'h00050000);
        // zero normal: reach equals the radius
        send_word(OP_CIRCLE, 32'h7FFFFFFF, 32'h80000000, 32'h0,
                  16'h0, 16'h0, 16'h0, 31'h7FFFFFFF);
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 31'h0);
        // normal not of unit length
        send_word(OP_CIRCLE, 32'h00100000, 32'hFFF00000, 32'h00000001,
                  16'h4000, 16'hC000, 16'h2D41, 31'h00010000);
        send_word(OP_CIRCLE, 32'h0, 32'h0, 32'h0, 16'h0001, 16'hFFFF, 16'h7FFF, 31'h1);
        send_word(OP_CIRCLE, 32'h12345678, 32'h9ABCDEF0, 32'h55555555,
                  16'hAAAA, 16'h5555, 16'h8001, 31'h2AAAAAAA);
        send_word(OP_POINT, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF,
                  16'hAAAA, 16'h5555, 16'hFFFF, 31'h55555555);
        send_word(OP_SPHERE, 32'h55555555, 32'hAAAAAAAA, 32'h00000000,
                  16'h5555, 16'hAAAA, 16'h0000, 31'h55555555);
        send_word(OP_CLEAR, 32'hAAAAAAAA, 32'h55555555, 32'h0, 16'hAAAA, 16'h5555, 16'h0,
                  31'h2AAAAAAA);
    endtask

    task automatic test_random_mix(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < count; k++) send_random_word();
    endtask

    // output held off long enough for the block to stall its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 400;
        for (int k = 0; k < 20; k++) send_random_word();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_POINT;
        i_m_axis_tready = 1'b0;
        empty_box();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_cases();
        test_random_mix(440, 0, 0);
        test_random_mix(440, 78, 0);
        test_random_mix(440, 0, 78);
        test_random_mix(440, 21, 21);
        test_output_backpressure();
        test_random_mix(40, 21, 21);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait (box_result_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
